### hdl/rlag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlag_pkg
// Shared types and constants of the windowed robust lag estimator.
// ----------------------------------------------------------------------------
package rlag_pkg;

   localparam int MAX_WINDOW = 128;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int CNT_W      = 8;
   localparam int LAG_BITS   = 32;
   localparam int SUM_W      = LAG_BITS + ADDR_W;
   localparam int ACC_W      = 64;

   localparam logic [29:0]      NSEC_PER_SEC      = 30'd1000000000;
   localparam logic [CNT_W-1:0] WINDOW_RESET      = 8'd100;
   localparam logic [CNT_W-1:0] MIN_SAMPLES_RESET = 8'd10;
   localparam logic [CNT_W-1:0] WINDOW_MIN        = 8'd2;
   localparam logic [CNT_W-1:0] WINDOW_MAX        = CNT_W'(MAX_WINDOW);

   localparam logic [7:0] CSR_WINDOW_SIZE = 8'd0;
   localparam logic [7:0] CSR_MIN_SAMPLES = 8'd1;

   localparam logic ACTION_PING     = 1'b0;
   localparam logic ACTION_RESPONSE = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] stamp_sec;
      logic [29:0] stamp_nsec;
      logic [31:0] now_sec;
      logic [29:0] now_nsec;
   } req_type;

   typedef struct packed {
      logic [LAG_BITS-1:0] lag_estimate;
      logic                estimate_valid;
      logic                sample_accepted;
      logic [CNT_W-1:0]    sample_count;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;

endpackage

### hdl/rlag_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlag_cell
// One sorting cell: keeps the smaller value, hands the larger one right.
// ----------------------------------------------------------------------------
module rlag_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  rlag_pkg::cell_ctl_type        ctl,
   input  logic                          in_valid,
   input  logic [rlag_pkg::LAG_BITS-1:0] in_data,
   input  logic [rlag_pkg::LAG_BITS-1:0] right_value,
   output logic                          out_valid,
   output logic [rlag_pkg::LAG_BITS-1:0] out_data,
   output logic [rlag_pkg::LAG_BITS-1:0] held_value
);

   logic                          full_ff;
   logic                          out_valid_ff;
   logic [rlag_pkg::LAG_BITS-1:0] value_ff;
   logic [rlag_pkg::LAG_BITS-1:0] out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         full_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid && full_ff;
         if (in_valid && !full_ff) begin
            full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         value_ff <= right_value;
      end else if (in_valid) begin
         if (!full_ff) begin
            value_ff <= in_data;
         end else if (in_data < value_ff) begin
            value_ff    <= in_data;
            out_data_ff <= value_ff;
         end else begin
            out_data_ff <= in_data;
         end
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;
   assign held_value = value_ff;

endmodule

### hdl/rlag_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlag_div
// Restoring divider: 64-bit dividend by sample count, one bit per cycle.
// ----------------------------------------------------------------------------
module rlag_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rlag_pkg::ACC_W-1:0]    dividend,
   input  logic [rlag_pkg::CNT_W-1:0]    divisor,
   output logic                          done,
   output logic [rlag_pkg::ACC_W-1:0]    quotient
);

   localparam int STEP_W = $clog2(rlag_pkg::ACC_W);

   logic                         busy_ff;
   logic                         done_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [rlag_pkg::ACC_W-1:0]   quo_ff;
   logic [rlag_pkg::CNT_W-1:0]   rem_ff;
   logic [rlag_pkg::CNT_W:0]     trial;
   logic                         fits;

   assign trial = {rem_ff, quo_ff[rlag_pkg::ACC_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(rlag_pkg::ACC_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         quo_ff  <= {quo_ff[rlag_pkg::ACC_W-2:0], fits};
         rem_ff  <= fits ? rlag_pkg::CNT_W'(trial - {1'b0, divisor})
                         : rlag_pkg::CNT_W'(trial);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/rlag_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlag_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rlag_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rlag_pkg::ACC_W-1:0]    radicand,
   output logic                          done,
   output logic [rlag_pkg::LAG_BITS:0]   root
);

   logic                       busy_ff;
   logic                       done_ff;
   logic [rlag_pkg::ACC_W-1:0] v_ff;
   logic [rlag_pkg::ACC_W-1:0] r_ff;
   logic [rlag_pkg::ACC_W-1:0] bit_ff;
   logic [rlag_pkg::ACC_W-1:0] trial;

   assign trial = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff == rlag_pkg::ACC_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         r_ff   <= '0;
         bit_ff <= rlag_pkg::ACC_W'(1) << (rlag_pkg::ACC_W - 2);
      end else if (busy_ff) begin
         bit_ff <= bit_ff >> 2;
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
      end
   end

   assign done = done_ff;
   assign root = r_ff[rlag_pkg::LAG_BITS:0];

endmodule

### hdl/windowed_robust_lag_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_robust_lag_estimator_top
// Ping lag estimator: ring window, mean/sd band, sorting cell chain.
// Flow: a ping or unmatched echo goes straight to the done state; a stored
//   sample first takes three memory passes, two divisions, a square root
//   and a shift-out of the cell chain.
// Throughput: one request at a time; processing and response stalls set it.
// Reset: synchronous; registers to 100 / 10, counters and ping stamp to zero.
// ----------------------------------------------------------------------------
module windowed_robust_lag_estimator_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rlag_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rlag_pkg::rsp_type    rsp_data,
   input  logic                 csr_write_enable,
   input  logic [7:0]           csr_index,
   input  logic [7:0]           csr_write_data
);

   localparam int LB = rlag_pkg::LAG_BITS;
   localparam int CW = rlag_pkg::CNT_W;
   localparam int AW = rlag_pkg::ADDR_W;
   localparam int NC = rlag_pkg::MAX_WINDOW;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_ADD   = 4'd2;
   localparam logic [3:0] ST_WR    = 4'd3;
   localparam logic [3:0] ST_P1    = 4'd4;
   localparam logic [3:0] ST_DIVM  = 4'd5;
   localparam logic [3:0] ST_P2    = 4'd6;
   localparam logic [3:0] ST_DIVV  = 4'd7;
   localparam logic [3:0] ST_SQRT  = 4'd8;
   localparam logic [3:0] ST_TH    = 4'd9;
   localparam logic [3:0] ST_P3    = 4'd10;
   localparam logic [3:0] ST_MID   = 4'd11;
   localparam logic [3:0] ST_SHIFT = 4'd12;
   localparam logic [3:0] ST_DONE  = 4'd13;

   logic [3:0]                state_ff, state_in;
   logic [CW-1:0]             window_ff, min_samples_ff;
   logic [31:0]               ping_sec_ff;
   logic [29:0]               ping_nsec_ff;
   logic [AW-1:0]             slot_ff;
   logic [CW-1:0]             count_ff;
   logic [LB-1:0]             estimate_ff;
   logic                      accepted_ff;

   logic signed [32:0]        ds_ff;
   logic signed [30:0]        dn_ff;
   logic signed [63:0]        prod_ff;
   logic [LB-1:0]             lag_ff;

   logic [CW-1:0]             idx_ff;
   logic                      v1_ff, v2_ff;
   logic [LB-1:0]             mem [NC];
   logic [LB-1:0]             mem_q_ff;
   logic [rlag_pkg::SUM_W-1:0] sum_ff;
   logic [LB-1:0]             mean_ff;
   logic [2*LB-1:0]           sq_ff;
   logic [rlag_pkg::ACC_W-1:0] acc_ff;
   logic [LB:0]               sd_ff;
   logic signed [LB+2:0]      lo_ff, hi_ff;
   logic [CW-1:0]             cnt_lo_ff, cnt_hi_ff;
   logic [CW-1:0]             shift_ff;
   logic                      start_ff;

   logic                      rsp_valid_ff;
   rlag_pkg::rsp_type         rsp_ff;

   logic [CW-1:0]             win;
   logic                      match;
   logic signed [63:0]        rtt;
   logic [LB-1:0]             lag_in;
   logic [CW-1:0]             cnt_clip;
   logic [AW-1:0]             slot_clip;
   logic [AW-1:0]             wr_addr;
   logic [LB-1:0]             diff;
   logic signed [LB+2:0]      x_s;
   logic [CW-1:0]             low, high, mid;
   logic                      out_free;
   logic                      div_done, sqrt_done;
   logic [rlag_pkg::ACC_W-1:0] div_q;
   logic [LB:0]               sqrt_r;

   rlag_pkg::cell_ctl_type    ctl;
   logic                      c_valid [NC+1];
   logic [LB-1:0]             c_data  [NC+1];
   logic [LB-1:0]             c_held  [NC+1];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= rlag_pkg::WINDOW_RESET;
         min_samples_ff <= rlag_pkg::MIN_SAMPLES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rlag_pkg::CSR_WINDOW_SIZE: window_ff      <= csr_write_data;
            rlag_pkg::CSR_MIN_SAMPLES: min_samples_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign win = (window_ff < rlag_pkg::WINDOW_MIN) ? rlag_pkg::WINDOW_MIN :
                (window_ff > rlag_pkg::WINDOW_MAX) ? rlag_pkg::WINDOW_MAX : window_ff;

   assign match = req_data.stamp_sec == ping_sec_ff && req_data.stamp_nsec == ping_nsec_ff;
   assign req_ready = state_ff == ST_IDLE;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rtt = prod_ff + 64'(dn_ff);
   always_comb begin
      if (rtt < 0) begin
         lag_in = '0;
      end else if ((rtt >>> 1) > 64'(signed'({1'b0, {LB{1'b1}}}))) begin
         lag_in = '1;
      end else begin
         lag_in = LB'(rtt >>> 1);
      end
   end

   assign cnt_clip  = (count_ff > win) ? win : count_ff;
   assign slot_clip = ({1'b0, slot_ff} >= win) ? '0 : slot_ff;
   assign wr_addr   = (cnt_clip < win) ? cnt_clip[AW-1:0] : slot_clip;

   assign diff = (mem_q_ff >= mean_ff) ? mem_q_ff - mean_ff : mean_ff - mem_q_ff;
   assign x_s  = signed'({3'b000, mem_q_ff});

   assign low  = (cnt_lo_ff == count_ff) ? count_ff - 1'b1 : cnt_lo_ff;
   assign high = (cnt_hi_ff == '0) ? '0 : cnt_hi_ff - 1'b1;
   assign mid  = (high < low) ? low : low + ((high - low) >> 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) begin
            state_in = (req_data.action == rlag_pkg::ACTION_RESPONSE && match) ?
                       ST_MUL : ST_DONE;
         end
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = ST_WR;
         ST_WR:    state_in = ST_P1;
         ST_P1:    if (idx_ff == count_ff + 1'b1) state_in = ST_DIVM;
         ST_DIVM:  if (div_done) state_in = ST_P2;
         ST_P2:    if (idx_ff == count_ff + 2'd2) state_in = ST_DIVV;
         ST_DIVV:  if (div_done) state_in = ST_SQRT;
         ST_SQRT:  if (sqrt_done) state_in = ST_TH;
         ST_TH:    state_in = ST_P3;
         ST_P3:    if (idx_ff == count_ff + 1'b1) state_in = ST_MID;
         ST_MID:   state_in = ST_SHIFT;
         ST_SHIFT: if (shift_ff == '0) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ping_sec_ff  <= '0;
         ping_nsec_ff <= '0;
         slot_ff      <= '0;
         count_ff     <= '0;
         estimate_ff  <= '0;
         accepted_ff  <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == ST_P1 && state_in == ST_DIVM) ||
                     (state_ff == ST_P2 && state_in == ST_DIVV) ||
                     (state_ff == ST_DIVV && state_in == ST_SQRT);
         v1_ff    <= (state_ff == ST_P1 || state_ff == ST_P2 || state_ff == ST_P3) &&
                     idx_ff < count_ff;
         v2_ff    <= v1_ff && state_ff == ST_P2;
         if (state_ff == ST_IDLE && req_valid) begin
            accepted_ff <= 1'b0;
            if (req_data.action == rlag_pkg::ACTION_PING) begin
               ping_sec_ff  <= req_data.stamp_sec;
               ping_nsec_ff <= req_data.stamp_nsec;
            end
         end
         if (state_ff == ST_WR) begin
            accepted_ff <= 1'b1;
            if (cnt_clip < win) begin
               count_ff <= cnt_clip + 1'b1;
               slot_ff  <= (cnt_clip + 1'b1 >= win) ? '0 : AW'(cnt_clip + 1'b1);
            end else begin
               count_ff <= cnt_clip;
               slot_ff  <= ({1'b0, slot_clip} + 1'b1 >= win) ? '0 : slot_clip + 1'b1;
            end
         end
         if (state_ff == ST_SHIFT && shift_ff == '0) begin
            estimate_ff <= c_held[0];
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         ds_ff <= signed'({1'b0, req_data.now_sec}) - signed'({1'b0, req_data.stamp_sec});
         dn_ff <= signed'({1'b0, req_data.now_nsec}) - signed'({1'b0, req_data.stamp_nsec});
      end
      prod_ff <= 64'(ds_ff * signed'({1'b0, rlag_pkg::NSEC_PER_SEC}));
      lag_ff  <= lag_in;
   end

   // ring window
   always_ff @(posedge clock) begin
      if (state_ff == ST_WR) begin
         mem[wr_addr] <= lag_ff;
      end
      mem_q_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WR || state_ff == ST_DIVM || state_ff == ST_TH) begin
         idx_ff <= '0;
      end else if (state_ff == ST_P1 || state_ff == ST_P2 || state_ff == ST_P3) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (state_ff == ST_WR) begin
         sum_ff <= '0;
      end else if (state_ff == ST_P1 && v1_ff) begin
         sum_ff <= sum_ff + rlag_pkg::SUM_W'(mem_q_ff);
      end
      if (state_ff == ST_DIVM && div_done) begin
         mean_ff <= div_q[LB-1:0];
         acc_ff  <= '0;
      end
      sq_ff <= diff * diff;
      if (v2_ff) begin
         acc_ff <= ({1'b0, acc_ff} + {1'b0, sq_ff} > {1'b0, {rlag_pkg::ACC_W{1'b1}}}) ?
                   '1 : acc_ff + sq_ff;
      end
      if (sqrt_done) begin
         sd_ff <= sqrt_r;
      end
      if (state_ff == ST_TH) begin
         lo_ff     <= signed'({3'b000, mean_ff}) - signed'({2'b00, sd_ff});
         hi_ff     <= signed'({3'b000, mean_ff}) + signed'({2'b00, sd_ff});
         cnt_lo_ff <= '0;
         cnt_hi_ff <= '0;
      end else if (state_ff == ST_P3 && v1_ff) begin
         if (!(x_s > lo_ff)) cnt_lo_ff <= cnt_lo_ff + 1'b1;
         if (!(x_s > hi_ff)) cnt_hi_ff <= cnt_hi_ff + 1'b1;
      end
      if (state_ff == ST_MID) begin
         shift_ff <= mid;
      end else if (state_ff == ST_SHIFT && shift_ff != '0) begin
         shift_ff <= shift_ff - 1'b1;
      end
   end

   rlag_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff && state_ff != ST_SQRT),
      .dividend ((state_ff == ST_DIVM) ? rlag_pkg::ACC_W'(sum_ff) : acc_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   rlag_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff && state_ff == ST_SQRT),
      .radicand (div_q),
      .done     (sqrt_done),
      .root     (sqrt_r)
   );

   // sorting chain
   assign ctl.clear  = state_ff == ST_WR;
   assign ctl.shift  = state_ff == ST_SHIFT && shift_ff != '0;
   assign c_valid[0] = state_ff == ST_P1 && v1_ff;
   assign c_data[0]  = mem_q_ff;
   assign c_held[NC] = '0;

   for (genvar g = 0; g < NC; g++) begin : g_cell
      rlag_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .in_valid    (c_valid[g]),
         .in_data     (c_data[g]),
         .right_value (c_held[g+1]),
         .out_valid   (c_valid[g+1]),
         .out_data    (c_data[g+1]),
         .held_value  (c_held[g])
      );
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_ff.lag_estimate    <= estimate_ff;
         rsp_ff.estimate_valid  <= count_ff > min_samples_ff;
         rsp_ff.sample_accepted <= accepted_ff;
         rsp_ff.sample_count    <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rlag_pkg::WINDOW_MAX)
      else $error("sample count beyond window");

   a_pass_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P1 && v1_ff) |-> count_ff != '0)
      else $error("memory pass with empty window");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MID) |=> shift_ff < count_ff)
      else $error("midpoint outside window");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Lag estimator regression: directed pings and echoes (mismatches, repeats,
// negative and saturating round trips, window fill, wrap and shrink, config
// extremes), then random ping/echo traffic under several idle and stall
// phases. Every response is compared with an in-bench lag estimate model.
// ----------------------------------------------------------------------------
module testbench;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   rlag_pkg::req_type   req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rlag_pkg::rsp_type   rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [7:0]          csr_index = '0;
   logic [7:0]          csr_write_data = '0;

   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  fail_count = 0;
   rlag_pkg::rsp_type   expected_rsps[$];

   // estimator state
   logic [7:0]  window_size_reg;
   logic [7:0]  min_samples_reg;
   logic [31:0] lag_mem [rlag_pkg::MAX_WINDOW];
   int          ring_slot;
   int          lag_count;
   logic [31:0] last_ping_sec;
   logic [29:0] last_ping_nsec;
   logic [31:0] lag_estimate_reg;

   windowed_robust_lag_estimator_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rlag_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.lag_estimate !== want.lag_estimate)
               report_mismatch("lag_estimate", rsp_data.lag_estimate, want.lag_estimate);
            if (rsp_data.estimate_valid !== want.estimate_valid)
               report_mismatch("estimate_valid", rsp_data.estimate_valid,
                               want.estimate_valid);
            if (rsp_data.sample_accepted !== want.sample_accepted)
               report_mismatch("sample_accepted", rsp_data.sample_accepted,
                               want.sample_accepted);
            if (rsp_data.sample_count !== want.sample_count)
               report_mismatch("sample_count", rsp_data.sample_count, want.sample_count);
         end
      end
   end

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void update_estimate(input int n);
      logic [63:0] ordered [rlag_pkg::MAX_WINDOW];
      logic [63:0] total, sq_acc, avg, dev, sq, sd, x;
      longint      lo_thr, hi_thr;
      int          lo, hi, mid, j;
      bit          lo_hit, hi_hit;
      total = 0;
      sq_acc = 0;
      lo_hit = 0;
      hi_hit = 0;
      for (int i = 0; i < n; i++) total += lag_mem[i];
      avg = total / n;
      for (int i = 0; i < n; i++) begin
         x = lag_mem[i];
         dev = (x >= avg) ? x - avg : avg - x;
         sq = (dev > 64'hFFFF_FFFF) ? '1 : dev * dev;
         sq_acc = (sq_acc > ~sq) ? '1 : sq_acc + sq;
      end
      sd = root_floor(sq_acc / n);
      for (int i = 0; i < n; i++) begin
         x = lag_mem[i];
         j = i;
         while (j > 0 && ordered[j-1] > x) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = x;
      end
      lo_thr = longint'(avg) - longint'(sd);
      hi_thr = longint'(avg) + longint'(sd);
      lo = n - 1;
      hi = n - 1;
      for (int i = 0; i < n; i++) begin
         if (!lo_hit && longint'(ordered[i]) > lo_thr) begin
            lo = i;
            lo_hit = 1;
         end
         if (!hi_hit && longint'(ordered[i]) > hi_thr) begin
            hi = (i > 0) ? i - 1 : 0;
            hi_hit = 1;
         end
      end
      mid = (hi < lo) ? lo : lo + (hi - lo) / 2;
      lag_estimate_reg = ordered[mid][31:0];
   endfunction

   function automatic rlag_pkg::rsp_type predict_lag(input rlag_pkg::req_type r);
      rlag_pkg::rsp_type res;
      int      w;
      longint  rtt, lag;
      bit      took;
      took = 0;
      if (r.action == rlag_pkg::ACTION_PING) begin
         last_ping_sec = r.stamp_sec;
         last_ping_nsec = r.stamp_nsec;
      end else if (r.stamp_sec == last_ping_sec && r.stamp_nsec == last_ping_nsec) begin
         w = window_size_reg;
         if (w < rlag_pkg::WINDOW_MIN) w = rlag_pkg::WINDOW_MIN;
         if (w > rlag_pkg::MAX_WINDOW) w = rlag_pkg::MAX_WINDOW;
         rtt = (longint'(r.now_sec) - longint'(r.stamp_sec)) * 1000000000
               + (longint'(r.now_nsec) - longint'(r.stamp_nsec));
         lag = (rtt < 0) ? 0 : rtt / 2;
         if (lag > 64'hFFFF_FFFF) lag = 64'hFFFF_FFFF;
         if (lag_count > w) lag_count = w;
         if (lag_count < w) begin
            lag_mem[lag_count] = lag[31:0];
            lag_count++;
            ring_slot = (lag_count >= w) ? 0 : lag_count;
         end else begin
            if (ring_slot >= w) ring_slot = 0;
            lag_mem[ring_slot] = lag[31:0];
            ring_slot = (ring_slot + 1 >= w) ? 0 : ring_slot + 1;
         end
         update_estimate(lag_count);
         took = 1;
      end
      res.lag_estimate = lag_estimate_reg;
      res.estimate_valid = (lag_count > min_samples_reg);
      res.sample_accepted = took;
      res.sample_count = lag_count[7:0];
      return res;
   endfunction

   task automatic send_request(input rlag_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      expected_rsps = {expected_rsps, predict_lag(r)};
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [7:0] val);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == rlag_pkg::CSR_WINDOW_SIZE) window_size_reg = val;
      else if (idx == rlag_pkg::CSR_MIN_SAMPLES) min_samples_reg = val;
   endtask

   task automatic send_ping(input logic [31:0] s, input logic [29:0] ns);
      rlag_pkg::req_type r;
      r = '0;
      r.action = rlag_pkg::ACTION_PING;
      r.stamp_sec = s;
      r.stamp_nsec = ns;
      r.now_sec = $urandom;
      r.now_nsec = 30'($urandom);
      send_request(r);
   endtask

   task automatic send_echo(input logic [31:0] s, input logic [29:0] ns,
                            input logic [31:0] now_s, input logic [29:0] now_ns);
      rlag_pkg::req_type r;
      r.action = rlag_pkg::ACTION_RESPONSE;
      r.stamp_sec = s;
      r.stamp_nsec = ns;
      r.now_sec = now_s;
      r.now_nsec = now_ns;
      send_request(r);
   endtask

   task automatic ping_round(input int max_rtt_ns, input int repeats);
      logic [31:0] s, d;
      logic [29:0] ns, now_ns;
      longint      t;
      s = $urandom;
      ns = 30'($urandom_range(999999999));
      send_ping(s, ns);
      for (int k = 0; k < repeats; k++) begin
         t = longint'(ns) + $urandom_range(max_rtt_ns);
         d = 32'(t / 1000000000);
         now_ns = 30'(t % 1000000000);
         send_echo(s, ns, s + d, now_ns);
      end
   endtask

   task automatic test_directed();
      send_echo(0, 0, 0, 5);
      send_echo(0, 0, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
      send_ping(32'hFFFF_FFFF, 30'h3FFF_FFFF);
      send_echo(32'hFFFF_FFFF, 30'h3FFF_FFFE, 0, 0);
      send_echo(32'hFFFF_FFFF, 30'h3FFF_FFFF, 0, 0);
      send_echo(32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
      send_ping(100, 999999999);
      send_echo(100, 999999999, 200, 0);
      send_echo(100, 999999999, 101, 1000);
      send_echo(100, 999999999, 101, 1000);
      send_echo(101, 999999999, 101, 1000);
      send_ping(32'h5555_5555, 30'h2AAA_AAAA);
      send_echo(32'h5555_5555, 30'h2AAA_AAAA, 32'hAAAA_AAAA, 30'h1555_5555);
      for (int i = 0; i < 10; i++) ping_round(2000000, 1);
   endtask

   task automatic test_config_extremes();
      write_csr(rlag_pkg::CSR_WINDOW_SIZE, 8'd0);
      write_csr(rlag_pkg::CSR_MIN_SAMPLES, 8'd0);
      for (int i = 0; i < 6; i++) ping_round(1000, 1);
      write_csr(rlag_pkg::CSR_WINDOW_SIZE, 8'd255);
      write_csr(rlag_pkg::CSR_MIN_SAMPLES, 8'd255);
      for (int i = 0; i < 20; i++) ping_round(50000000, 1);
      write_csr(8'd2, 8'd77);
      write_csr(8'd255, 8'd3);
      write_csr(rlag_pkg::CSR_WINDOW_SIZE, 8'd8);
      write_csr(rlag_pkg::CSR_MIN_SAMPLES, 8'd128);
      for (int i = 0; i < 12; i++) ping_round(3000000, 1);
   endtask

   task automatic test_random(input int items, input int idle, input int stall);
      int sent;
      send_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(9))
            0: begin
               send_echo($urandom, 30'($urandom), $urandom, 30'($urandom));
               sent++;
            end
            1: begin
               ping_round(32'h7FFF_FFFF, 1);
               sent += 2;
            end
            2: begin
               send_ping($urandom, 30'($urandom));
               sent++;
            end
            default: begin
               ping_round((sent % 3 == 0) ? 100000 : 40000000, $urandom_range(1, 3));
               sent += 3;
            end
         endcase
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_window_sweep();
      write_csr(rlag_pkg::CSR_WINDOW_SIZE, 8'd128);
      write_csr(rlag_pkg::CSR_MIN_SAMPLES, 8'd5);
      test_random(140, 0, 0);
      write_csr(rlag_pkg::CSR_WINDOW_SIZE, 8'd2);
      test_random(30, 67, 0);
      write_csr(rlag_pkg::CSR_WINDOW_SIZE, 8'd37);
      write_csr(rlag_pkg::CSR_MIN_SAMPLES, 8'd20);
      test_random(140, 0, 67);
      write_csr(rlag_pkg::CSR_WINDOW_SIZE, 8'd16);
      test_random(130, 9, 9);
      wait_drained();
      test_random(60, 67, 67);
   endtask

   initial begin
      window_size_reg = rlag_pkg::WINDOW_RESET;
      min_samples_reg = rlag_pkg::MIN_SAMPLES_RESET;
      ring_slot = 0;
      lag_count = 0;
      last_ping_sec = '0;
      last_ping_nsec = '0;
      lag_estimate_reg = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_window_sweep();
      wait_drained();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

### windowed_robust_lag_estimator_top.f
hdl/rlag_pkg.sv
hdl/rlag_cell.sv
hdl/rlag_div.sv
hdl/rlag_sqrt.sv
hdl/windowed_robust_lag_estimator_top.sv
sim/testbench.sv
